[src/assert_macros.svh]
// Assertion helpers for the RTL, included by tvbp_back.
// TVBP_ASSERT checks a property on every rising clock edge outside reset.
// TVBP_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define TVBP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TVBP_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define TVBP_ASSERT(label, clk, rstn, prop, msg)
`define TVBP_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

[src/tvbp_pkg.sv]
`default_nettype none

package tvbp_pkg;

    // Frame layout
    localparam int DATASET_BYTES = 8;
    localparam int MAX_DATASETS  = 32;
    localparam int HEADER_BYTES  = 4;

    localparam int DS_BITS   = DATASET_BYTES * 8;
    // Bit window of the packer: leftover bits plus one validity bit and a dataset
    localparam int WORK_W    = DS_BITS + 8;
    localparam int REM_W     = $clog2(WORK_W + 1);
    localparam int FILL_W    = $clog2(DATASET_BYTES);
    localparam int DCNT_W    = $clog2(MAX_DATASETS + 2);
    localparam int HCNT_W    = $clog2(HEADER_BYTES + 1);
    localparam int BCNT_W    = 9;
    localparam int MAX_BYTES = HEADER_BYTES + (MAX_DATASETS * (DS_BITS + 1) + 7) / 8;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLTAGE_LOW     = 0,
        REG_VOLTAGE_HIGH    = 1,
        REG_BATT_CURRENT    = 2,
        REG_BUS_CURRENT_MAX = 3,
        REG_TEMP_MIN        = 4
    } cfg_reg_t;

    localparam logic [7:0] VOLTAGE_LOW_RST  = 8'd129;
    localparam logic [7:0] VOLTAGE_HIGH_RST = 8'd197;
    localparam logic [7:0] BATT_CURRENT_RST = 8'd64;
    localparam logic [7:0] BUS_CURRENT_RST  = 8'd115;
    localparam logic [7:0] TEMP_MIN_RST     = 8'd79;

    // What the back end has to do for one input beat
    typedef enum logic [1:0] {
        JOB_PASS = 2'd0,   // timestamp byte, sent as is
        JOB_DATA = 2'd1,   // complete dataset, validity bit then all bits
        JOB_SKIP = 2'd2    // nothing to send; carries a frame end only
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [DS_BITS-1:0] data;       // byte 0 in the top bits; PASS uses [7:0]
        logic               valid_bit;
        logic               last;       // frame closes after this job
        logic               err;        // frame error flag, meaningful with last
    } job_t;

endpackage

`default_nettype wire

[src/tvbp_queue.sv]
`default_nettype none

module tvbp_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire tvbp_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output tvbp_pkg::job_t     head
);

    tvbp_pkg::job_t                    mem_reg [tvbp_pkg::QUEUE_DEPTH];
    logic [tvbp_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [tvbp_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [tvbp_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    localparam logic [tvbp_pkg::QPTR_W-1:0] PTR_LAST = tvbp_pkg::QPTR_W'(tvbp_pkg::QUEUE_DEPTH - 1);
    localparam logic [tvbp_pkg::QCNT_W-1:0] CNT_FULL = tvbp_pkg::QCNT_W'(tvbp_pkg::QUEUE_DEPTH);

    assign full  = (cnt_reg == CNT_FULL);
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[src/tvbp_front.sv]
`default_nettype none

module tvbp_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,
    input  wire logic                              s_tlast,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tvbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [7:0]                        cfg_data,
    // job queue
    output logic                                   job_push,
    output tvbp_pkg::job_t                         job,
    input  wire logic                              q_full
);

    localparam logic [tvbp_pkg::HCNT_W-1:0] HDR_LEN  = tvbp_pkg::HCNT_W'(tvbp_pkg::HEADER_BYTES);
    localparam logic [tvbp_pkg::FILL_W-1:0] FILL_END = tvbp_pkg::FILL_W'(tvbp_pkg::DATASET_BYTES - 1);
    localparam logic [tvbp_pkg::DCNT_W-1:0] MAX_CNT  = tvbp_pkg::DCNT_W'(tvbp_pkg::MAX_DATASETS);

    logic [7:0] vlow_reg, vhigh_reg, bmin_reg, busmax_reg, tmin_reg;

    logic [tvbp_pkg::HCNT_W-1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [tvbp_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [tvbp_pkg::DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [7:0]                   buf_reg [tvbp_pkg::DATASET_BYTES];

    logic                         beat;
    logic                         in_hdr;
    logic                         ds_done;
    logic [tvbp_pkg::DCNT_W-1:0]  dcnt_new;
    logic                         emit_ds;
    logic [7:0]                   ds_byte [tvbp_pkg::DATASET_BYTES];
    logic [tvbp_pkg::DS_BITS-1:0] ds_vec;
    logic                         ds_valid;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign beat      = s_tvalid && s_tready;

    // Threshold registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vlow_reg   <= tvbp_pkg::VOLTAGE_LOW_RST;
            vhigh_reg  <= tvbp_pkg::VOLTAGE_HIGH_RST;
            bmin_reg   <= tvbp_pkg::BATT_CURRENT_RST;
            busmax_reg <= tvbp_pkg::BUS_CURRENT_RST;
            tmin_reg   <= tvbp_pkg::TEMP_MIN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tvbp_pkg::REG_VOLTAGE_LOW:     vlow_reg   <= cfg_data;
                tvbp_pkg::REG_VOLTAGE_HIGH:    vhigh_reg  <= cfg_data;
                tvbp_pkg::REG_BATT_CURRENT:    bmin_reg   <= cfg_data;
                tvbp_pkg::REG_BUS_CURRENT_MAX: busmax_reg <= cfg_data;
                tvbp_pkg::REG_TEMP_MIN:        tmin_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the beat
    assign in_hdr   = (hdr_cnt_reg < HDR_LEN);
    assign ds_done  = !in_hdr && (fill_reg == FILL_END);
    assign dcnt_new = dcnt_reg + tvbp_pkg::DCNT_W'(ds_done && (dcnt_reg <= MAX_CNT));
    assign emit_ds  = ds_done && (dcnt_new <= MAX_CNT);

    // Complete dataset: the current beat supplies the final byte
    always_comb begin
        ds_vec = '0;
        for (int i = 0; i < tvbp_pkg::DATASET_BYTES; i++) begin
            ds_byte[i] = (i == tvbp_pkg::DATASET_BYTES - 1) ? s_tdata : buf_reg[i];
            ds_vec[tvbp_pkg::DS_BITS-1-8*i -: 8] = ds_byte[i];
        end
    end

    // Eight range checks over dataset bytes 0 to 6
    assign ds_valid = (ds_byte[0] > vlow_reg) && (ds_byte[0] < vhigh_reg)
                   && (ds_byte[1] > bmin_reg)
                   && (ds_byte[2] < busmax_reg) && (ds_byte[3] < busmax_reg)
                   && (ds_byte[4] > tmin_reg) && (ds_byte[5] > tmin_reg)
                   && (ds_byte[6] > tmin_reg);

    // Job for the back end
    always_comb begin
        job.valid_bit = ds_valid;
        job.last      = s_tlast;
        job.err       = (dcnt_new == '0) || (dcnt_new > MAX_CNT);
        if (in_hdr) begin
            job.kind = tvbp_pkg::JOB_PASS;
            job.data = tvbp_pkg::DS_BITS'(s_tdata);
        end else if (emit_ds) begin
            job.kind = tvbp_pkg::JOB_DATA;
            job.data = ds_vec;
        end else begin
            job.kind = tvbp_pkg::JOB_SKIP;
            job.data = ds_vec;
        end
    end

    assign job_push = beat && (in_hdr || emit_ds || s_tlast);

    // Frame position counters
    always_comb begin
        hdr_cnt_next = hdr_cnt_reg;
        fill_next    = fill_reg;
        dcnt_next    = dcnt_reg;
        if (beat) begin
            if (s_tlast) begin
                hdr_cnt_next = '0;
                fill_next    = '0;
                dcnt_next    = '0;
            end else if (in_hdr) begin
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
            end else begin
                fill_next = ds_done ? '0 : fill_reg + 1'b1;
                dcnt_next = dcnt_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg <= '0;
            fill_reg    <= '0;
            dcnt_reg    <= '0;
        end else begin
            hdr_cnt_reg <= hdr_cnt_next;
            fill_reg    <= fill_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    // Dataset buffer
    always_ff @(posedge aclk) begin
        if (beat && !in_hdr) begin
            buf_reg[fill_reg] <= s_tdata;
        end
    end

endmodule

`default_nettype wire

[src/tvbp_back.sv]
`default_nettype none

`include "assert_macros.svh"

module tvbp_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // job queue
    input  wire logic            q_empty,
    input  wire tvbp_pkg::job_t  head,
    output logic                 q_pop,
    // result stream
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EMIT  = 4'b0010,
        S_PAD   = 4'b0100,
        S_CLOSE = 4'b1000
    } state_t;

    localparam logic [tvbp_pkg::REM_W-1:0]  REM_BYTE = tvbp_pkg::REM_W'(8);
    localparam logic [tvbp_pkg::REM_W-1:0]  REM_JOB  = tvbp_pkg::REM_W'(tvbp_pkg::DS_BITS + 1);
    localparam logic [tvbp_pkg::BCNT_W-1:0] CNT_MAX  = tvbp_pkg::BCNT_W'(tvbp_pkg::MAX_BYTES);

    state_t                          state_reg, state_next;
    logic [tvbp_pkg::WORK_W-1:0]     work_reg, work_next;
    logic [tvbp_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [tvbp_pkg::REM_W-1:0]      rem_dec;
    logic [7:0]                      acc_reg, acc_next;     // left aligned
    logic [2:0]                      fill_reg, fill_next;
    logic [tvbp_pkg::BCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            err_reg, err_next;
    logic                            last_reg, last_next;

    logic                            m_valid_reg, m_valid_next;
    logic [7:0]                      obyte_reg;
    logic                            ohas_reg, olast_reg, oerr_reg;
    logic [tvbp_pkg::BCNT_W-1:0]     ocnt_reg;

    logic                            out_free;
    logic                            load_out;
    logic [7:0]                      ld_byte;
    logic                            ld_has, ld_last, ld_err;
    logic [tvbp_pkg::BCNT_W-1:0]     ld_cnt;

    assign out_free = !m_valid_reg || m_tready;
    assign rem_dec  = rem_reg - REM_BYTE;

    // Sequencer: pops jobs and feeds the output register one beat at a time
    always_comb begin
        state_next = state_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        ld_byte    = '0;
        ld_has     = 1'b1;
        ld_last    = 1'b0;
        ld_err     = 1'b0;
        ld_cnt     = '0;

        case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    case (head.kind)
                        tvbp_pkg::JOB_PASS: begin
                            if (out_free) begin
                                q_pop     = 1'b1;
                                load_out  = 1'b1;
                                ld_byte   = head.data[7:0];
                                cnt_next  = cnt_reg + 1'b1;
                                err_next  = head.err;
                                last_next = head.last;
                                if (head.last) begin
                                    state_next = S_PAD;
                                end
                            end
                        end
                        tvbp_pkg::JOB_DATA: begin
                            // merge leftover bits with validity bit and dataset
                            q_pop      = 1'b1;
                            work_next  = {acc_reg, {tvbp_pkg::DS_BITS{1'b0}}}
                                       | ({head.valid_bit, head.data, 7'b0} >> fill_reg);
                            rem_next   = tvbp_pkg::REM_W'(fill_reg) + REM_JOB;
                            err_next   = head.err;
                            last_next  = head.last;
                            state_next = S_EMIT;
                        end
                        tvbp_pkg::JOB_SKIP: begin
                            q_pop     = 1'b1;
                            err_next  = head.err;
                            last_next = head.last;
                            if (head.last) begin
                                state_next = S_PAD;
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out  = 1'b1;
                    ld_byte   = work_reg[tvbp_pkg::WORK_W-1 -: 8];
                    cnt_next  = cnt_reg + 1'b1;
                    work_next = work_reg << 8;
                    rem_next  = rem_dec;
                    if (rem_dec < REM_BYTE) begin
                        acc_next   = work_reg[tvbp_pkg::WORK_W-9 -: 8];
                        fill_next  = rem_dec[2:0];
                        state_next = last_reg ? S_PAD : S_IDLE;
                    end
                end
            end
            S_PAD: begin
                if (fill_reg == '0) begin
                    state_next = S_CLOSE;
                end else if (out_free) begin
                    load_out   = 1'b1;
                    ld_byte    = acc_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    acc_next   = '0;
                    fill_next  = '0;
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    ld_has     = 1'b0;
                    ld_last    = 1'b1;
                    ld_err     = err_reg;
                    ld_cnt     = cnt_reg;
                    cnt_next   = '0;
                    acc_next   = '0;
                    fill_next  = '0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = load_out || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rem_reg     <= '0;
            acc_reg     <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rem_reg     <= rem_next;
            acc_reg     <= acc_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Bit window and output payload
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        if (load_out) begin
            obyte_reg <= ld_byte;
            ohas_reg  <= ld_has;
            olast_reg <= ld_last;
            oerr_reg  <= ld_err;
            ocnt_reg  <= ld_cnt;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, ocnt_reg, oerr_reg, obyte_reg};
    assign m_tuser  = ohas_reg;
    assign m_tlast  = olast_reg;

    `TVBP_ASSERT(a_emit_has_byte, aclk, aresetn, (state_reg == S_EMIT) |-> (rem_reg >= REM_BYTE), "emit state without a full byte")
    `TVBP_ASSERT(a_acc_clean, aclk, aresetn, (fill_reg == '0) |-> (acc_reg == '0), "stale bits in empty accumulator")
    `TVBP_ASSERT(a_pop_idle, aclk, aresetn, q_pop |-> (state_reg == S_IDLE && !q_empty), "job taken outside idle")
    `TVBP_ASSERT(a_close_clears, aclk, aresetn, (state_reg == S_CLOSE && out_free) |=> (cnt_reg == '0 && state_reg == S_IDLE), "frame state kept after close")
    `TVBP_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > CNT_MAX, "byte count beyond frame maximum")

endmodule

`default_nettype wire

[src/telemetry_validity_bit_packer.sv]
// Channel   Direction  Ports                       Payload
// s_        in         s_tvalid/s_tready           tdata[7:0] in_byte, tlast frame_end
// m_        out        m_tvalid/m_tready           tdata out_byte/frame_error/byte_count,
//                                                  tuser has_byte, tlast is_last
// cfg_      in         cfg_valid/cfg_ready         cfg_index register, cfg_data value
//
// Input bytes are taken one per cycle while the two-entry job queue has room.
// A timestamp byte is on the output in the cycle after it is popped; a complete
// dataset is popped and then drains as 8 or 9 output beats, one per cycle while
// the receiver is ready (m_tready high).
// A frame end adds a padding beat (when bits are left) and the closing beat.
// Reset is synchronous on aresetn; no clearing pass is needed afterwards.
// Output back-pressure stalls only the back end until the queue fills.
`default_nettype none

module telemetry_validity_bit_packer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] in_byte
    input  wire logic                              s_tlast,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [23:0]                            m_tdata,   // [7:0] out_byte, [8] frame_error,
                                                              // [17:9] byte_count, [23:18] zero
    output logic                                   m_tuser,   // [0] has_byte
    output logic                                   m_tlast,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tvbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [7:0]                        cfg_data
);

    tvbp_pkg::job_t push_job;
    tvbp_pkg::job_t head_job;
    logic           job_push;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    // Byte intake, dataset buffer and range checks
    tvbp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_push  (job_push),
        .job       (push_job),
        .q_full    (q_full)
    );

    // Job queue
    tvbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (head_job)
    );

    // Bit packer and output register
    tvbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head     (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[tb/sv/telemetry_validity_bit_packer_tb.sv]
module telemetry_validity_bit_packer_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 24;
    localparam logic [tvbp_pkg::CFG_IDX_W-1:0] NO_SUCH_REG = 3'd7;

    // one result beat, split into its fields
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       is_last;
        logic       frame_error;
        logic [8:0] byte_count;
    } beat_t;

    // Tracks thresholds and frame state, predicts the packed stream
    class packer_scoreboard;
        logic [7:0] v_low, v_high, i_batt, i_bus_max, t_min;
        logic [2:0] hdr_seen;
        logic [7:0] ds_bytes [tvbp_pkg::DATASET_BYTES];
        logic [3:0] ds_fill;
        logic [7:0] acc;
        logic [3:0] acc_fill;
        logic [5:0] ds_count;
        logic [8:0] emitted;
        beat_t      pending_beats [$];
        int         mismatches;

        function new();
            v_low      = tvbp_pkg::VOLTAGE_LOW_RST;
            v_high     = tvbp_pkg::VOLTAGE_HIGH_RST;
            i_batt     = tvbp_pkg::BATT_CURRENT_RST;
            i_bus_max  = tvbp_pkg::BUS_CURRENT_RST;
            t_min      = tvbp_pkg::TEMP_MIN_RST;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            hdr_seen = '0;
            ds_fill  = '0;
            acc      = '0;
            acc_fill = '0;
            ds_count = '0;
            emitted  = '0;
        endfunction

        function void set_threshold(logic [tvbp_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                tvbp_pkg::REG_VOLTAGE_LOW:     v_low = val;
                tvbp_pkg::REG_VOLTAGE_HIGH:    v_high = val;
                tvbp_pkg::REG_BATT_CURRENT:    i_batt = val;
                tvbp_pkg::REG_BUS_CURRENT_MAX: i_bus_max = val;
                tvbp_pkg::REG_TEMP_MIN:        t_min = val;
                default: ;  // unmapped index, write dropped
            endcase
        endfunction

        function void emit_byte(logic [7:0] b);
            pending_beats.push_back(beat_t'{out_byte: b, has_byte: 1'b1, is_last: 1'b0,
                                            frame_error: 1'b0, byte_count: 9'd0});
            emitted = emitted + 9'd1;
        endfunction

        function void push_bit(logic bit_in);
            acc      = {acc[6:0], bit_in};
            acc_fill = acc_fill + 4'd1;
            if (acc_fill == 4'd8) begin
                emit_byte(acc);
                acc      = '0;
                acc_fill = '0;
            end
        endfunction

        // eight strict range checks on the buffered dataset
        function logic dataset_ok();
            return ds_bytes[0] > v_low && ds_bytes[0] < v_high
                && ds_bytes[1] > i_batt
                && ds_bytes[2] < i_bus_max && ds_bytes[3] < i_bus_max
                && ds_bytes[4] > t_min && ds_bytes[5] > t_min && ds_bytes[6] > t_min;
        endfunction

        // note one accepted input beat and queue the beats it causes
        function void take_byte(logic [7:0] b, logic frame_end);
            logic err;
            if (hdr_seen < tvbp_pkg::HEADER_BYTES) begin
                hdr_seen = hdr_seen + 3'd1;
                emit_byte(b);
            end else begin
                ds_bytes[ds_fill[2:0]] = b;
                ds_fill = ds_fill + 4'd1;
                if (ds_fill == tvbp_pkg::DATASET_BYTES) begin
                    ds_fill = '0;
                    if (ds_count <= tvbp_pkg::MAX_DATASETS)
                        ds_count = ds_count + 6'd1;
                    if (ds_count <= tvbp_pkg::MAX_DATASETS) begin
                        push_bit(dataset_ok());
                        for (int i = 0; i < tvbp_pkg::DATASET_BYTES; i++)
                            for (int j = 7; j >= 0; j--)
                                push_bit(ds_bytes[i][j]);
                    end
                end
            end
            if (frame_end) begin
                if (acc_fill != 0) begin
                    emit_byte(acc << (4'd8 - acc_fill));
                    acc      = '0;
                    acc_fill = '0;
                end
                err = (ds_count == 0 || ds_count > tvbp_pkg::MAX_DATASETS);
                pending_beats.push_back(beat_t'{out_byte: 8'd0, has_byte: 1'b0, is_last: 1'b1,
                                                frame_error: err, byte_count: emitted});
                clear_frame();
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        // compare one accepted result beat with the oldest prediction
        function void check_beat(beat_t got);
            beat_t want;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_beats.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("has_byte", want.has_byte, got.has_byte);
            compare_field("is_last", want.is_last, got.is_last);
            compare_field("frame_error", want.frame_error, got.frame_error);
            compare_field("byte_count", want.byte_count, got.byte_count);
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [23:0]                    m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tvbp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                     cfg_data;

    packer_scoreboard tracker = new();
    logic [7:0]       frame_q [$];
    int               items_sent = 0;
    int               cycle_count = 0;
    bit               calm = 1'b0;
    bit               hold_request = 1'b0;

    telemetry_validity_bit_packer dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // input beats feed the prediction, result beats are checked
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            tracker.take_byte(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready)
            tracker.check_beat(beat_t'{out_byte: m_tdata[7:0], has_byte: m_tuser,
                                       is_last: m_tlast, frame_error: m_tdata[8],
                                       byte_count: m_tdata[17:9]});
    end

    // receiver: random stall bursts plus one long hold-off on request
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = LONG_HOLD;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // send the queued frame, tlast on its final byte
    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    function automatic void add_random(int n);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // dataset byte biased into its check window, sometimes right on a bound
    function automatic logic [7:0] pick_field(int pos);
        int lo, hi, r, v;
        case (pos)
            0:       begin lo = tracker.v_low + 1;  hi = tracker.v_high - 1;    end
            1:       begin lo = tracker.i_batt + 1; hi = 255;                   end
            2, 3:    begin lo = 0;                  hi = tracker.i_bus_max - 1; end
            4, 5, 6: begin lo = tracker.t_min + 1;  hi = 255;                   end
            default: begin lo = 0;                  hi = 255;                   end
        endcase
        r = $urandom_range(0, 39);
        if (r < 2) begin
            v = (r == 0) ? lo - 1 : hi + 1;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
        end else if (r < 4 || lo > hi) begin
            v = $urandom_range(0, 255);
        end else begin
            v = $urandom_range(hi, lo);
        end
        return v[7:0];
    endfunction

    function automatic void add_dataset();
        for (int i = 0; i < tvbp_pkg::DATASET_BYTES; i++)
            frame_q.push_back(pick_field(i));
    endfunction

    task automatic random_frame();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            add_random($urandom_range(1, tvbp_pkg::HEADER_BYTES));  // ends inside timestamp
        end else if (kind == 1) begin
            add_random($urandom_range(tvbp_pkg::HEADER_BYTES + 1, 20));  // raw noise
        end else begin
            add_random(tvbp_pkg::HEADER_BYTES);
            repeat ($urandom_range(1, 3)) add_dataset();
            if ($urandom_range(0, 2) == 0)
                add_random($urandom_range(1, tvbp_pkg::DATASET_BYTES - 1));
        end
        send_frame();
    endtask

    task automatic random_phase(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n) begin
            calm = ($urandom_range(0, 5) == 0);
            random_frame();
        end
        calm = 1'b0;
    endtask

    // wait for all predicted beats plus the drain time of a dataset
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tvbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_threshold(idx, val);
    endtask

    task automatic set_thresholds(input logic [7:0] vl, vh, ib, ibus, tm);
        write_reg(NO_SUCH_REG, 8'hFF);
        write_reg(tvbp_pkg::REG_VOLTAGE_LOW, vl);
        write_reg(tvbp_pkg::REG_VOLTAGE_HIGH, vh);
        write_reg(tvbp_pkg::REG_BATT_CURRENT, ib);
        write_reg(tvbp_pkg::REG_BUS_CURRENT_MAX, ibus);
        write_reg(tvbp_pkg::REG_TEMP_MIN, tm);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // frame ending on its first timestamp byte
        frame_q = '{8'h00};
        send_frame();
        // timestamp only, no dataset
        frame_q = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
        send_frame();
        // one dataset passing all checks, then a partial dataset that is dropped
        frame_q = '{8'h12, 8'h34, 8'h56, 8'h78, 8'd150, 8'd65, 8'd0, 8'd114,
                    8'd80, 8'd255, 8'd200, 8'hFF, 8'h80, 8'h01};
        send_frame();
        // timestamp plus a partial dataset only
        frame_q = '{8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        send_frame();
        random_phase(8);

        // widest windows
        settle();
        set_thresholds(8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
        random_phase(8);

        // closed windows, every dataset fails
        settle();
        set_thresholds(8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        random_phase(8);

        settle();
        set_thresholds(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        random_phase(8);

        settle();
        set_thresholds(tvbp_pkg::VOLTAGE_LOW_RST, tvbp_pkg::VOLTAGE_HIGH_RST,
                       tvbp_pkg::BATT_CURRENT_RST, tvbp_pkg::BUS_CURRENT_RST,
                       tvbp_pkg::TEMP_MIN_RST);

        // receiver holds off while the sender keeps pushing
        hold_request = 1'b1;
        add_random(tvbp_pkg::HEADER_BYTES);
        repeat (2) add_dataset();
        send_frame();

        // closing stretch without idling
        calm = 1'b1;
        random_frame();
        settle();

        if (tracker.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
